[rtl/core/i2cm_pkg.sv]
// Package with the word types, state layout and codes of the I2C master bit engine.
package i2cm_pkg;

	// Command and tick kinds carried by an input word.
	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_STOP  = 3'd1;
	localparam logic [2:0] KIND_WACK  = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;
	localparam logic [2:0] KIND_TICK  = 3'd5;

	// Sequencer phase codes.
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_S1   = 4'd1;
	localparam logic [3:0] PH_S2   = 4'd2;
	localparam logic [3:0] PH_P1   = 4'd3;
	localparam logic [3:0] PH_P2   = 4'd4;
	localparam logic [3:0] PH_W1   = 4'd5;
	localparam logic [3:0] PH_W2   = 4'd6;
	localparam logic [3:0] PH_W3   = 4'd7;
	localparam logic [3:0] PH_T1   = 4'd8;
	localparam logic [3:0] PH_T2   = 4'd9;
	localparam logic [3:0] PH_T3   = 4'd10;
	localparam logic [3:0] PH_R1   = 4'd11;
	localparam logic [3:0] PH_R2   = 4'd12;
	localparam logic [3:0] PH_A1   = 4'd13;
	localparam logic [3:0] PH_A2   = 4'd14;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_HOLD    = 2'd0;
	localparam logic [1:0] REG_HALF    = 2'd1;
	localparam logic [1:0] REG_SETUP   = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	// Bits in a full byte transfer.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       ack_after_read;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
		logic       rejected;
	} res_t;

	typedef struct packed {
		logic [7:0] start_stop_hold;
		logic [7:0] bit_half_period;
		logic [7:0] ack_setup;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] delay_count;
		logic [3:0] bit_index;
		logic [7:0] shift_data;
		logic [7:0] timeout_count;
		logic       ack_choice;
		logic       pin_scl;
		logic       pin_sda;
		logic       pin_drive;
		logic       stop_for_ack;
		logic [7:0] rx_last;
	} state_t;

	// Per-word flags that do not persist in the state.
	typedef struct packed {
		logic done;
		logic missing;
		logic rejected;
	} flags_t;

endpackage

[rtl/core/i2cm_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface i2cm_cmd_if;
	logic           valid;
	logic           ready;
	i2cm_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
	logic           valid;
	logic           ready;
	i2cm_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2cm_cfg.sv]
// Configuration register bank of the I2C master bit engine.
module i2cm_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  logic [1:0]     index,
	input  logic [7:0]     wdata,
	output i2cm_pkg::cfg_t cfg
);
	import i2cm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_stop_hold <= 8'd5;
			cfg_q.bit_half_period <= 8'd2;
			cfg_q.ack_setup       <= 8'd1;
			cfg_q.ack_timeout     <= 8'd250;
		end else if (we) begin
			unique case (index)
				REG_HOLD:    cfg_q.start_stop_hold <= wdata;
				REG_HALF:    cfg_q.bit_half_period <= wdata;
				REG_SETUP:   cfg_q.ack_setup       <= wdata;
				REG_TIMEOUT: cfg_q.ack_timeout     <= wdata;
				default:     cfg_q.ack_timeout     <= wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/i2cm_step.sv]
// Next-state and flag logic for one command or tick word.
module i2cm_step (
	input  i2cm_pkg::state_t st,
	input  i2cm_pkg::cfg_t   cfg,
	input  i2cm_pkg::cmd_t   cmd,
	output i2cm_pkg::state_t nx,
	output i2cm_pkg::flags_t flags
);
	import i2cm_pkg::*;

	logic       seg_over;
	logic [7:0] dly_dec;
	logic [3:0] bit_inc;
	logic [7:0] rd_shift;

	always_comb begin
		nx       = st;
		flags    = '0;
		seg_over = (st.delay_count <= 8'd1);
		dly_dec  = seg_over ? 8'd0 : (st.delay_count - 8'd1);
		bit_inc  = st.bit_index + 4'd1;
		rd_shift = {st.shift_data[6:0], cmd.sda_in};

		if (cmd.kind <= KIND_READ) begin
			if (st.phase != PH_IDLE) begin
				flags.rejected = 1'b1;
			end else begin
				unique case (cmd.kind)
					KIND_START: begin
						nx.pin_drive   = 1'b1;
						nx.pin_sda     = 1'b1;
						nx.pin_scl     = 1'b1;
						nx.delay_count = cfg.start_stop_hold;
						nx.phase       = PH_S1;
					end
					KIND_STOP: begin
						nx.stop_for_ack = 1'b0;
						nx.pin_drive    = 1'b1;
						nx.pin_scl      = 1'b0;
						nx.pin_sda      = 1'b0;
						nx.delay_count  = cfg.start_stop_hold;
						nx.phase        = PH_P1;
					end
					KIND_WACK: begin
						nx.pin_drive   = 1'b0;
						nx.pin_sda     = 1'b1;
						nx.delay_count = cfg.ack_setup;
						nx.phase       = PH_W1;
					end
					KIND_WRITE: begin
						nx.pin_drive   = 1'b1;
						nx.pin_scl     = 1'b0;
						nx.bit_index   = 4'd0;
						nx.pin_sda     = cmd.tx_byte[7];
						nx.shift_data  = {cmd.tx_byte[6:0], 1'b0};
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_T1;
					end
					default: begin
						nx.pin_drive   = 1'b0;
						nx.shift_data  = 8'd0;
						nx.bit_index   = 4'd0;
						nx.ack_choice  = cmd.ack_after_read;
						nx.pin_scl     = 1'b0;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_R1;
					end
				endcase
			end
		end else if (cmd.kind == KIND_TICK) begin
			unique case (st.phase)
				PH_IDLE: begin
					nx.phase = PH_IDLE;
				end
				PH_S1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_sda     = 1'b0;
						nx.delay_count = cfg.start_stop_hold;
						nx.phase       = PH_S2;
					end
				end
				PH_S2: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl = 1'b0;
						nx.phase   = PH_IDLE;
						flags.done = 1'b1;
					end
				end
				PH_P1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl     = 1'b1;
						nx.delay_count = cfg.start_stop_hold;
						nx.phase       = PH_P2;
					end
				end
				PH_P2: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_sda      = 1'b1;
						nx.phase        = PH_IDLE;
						flags.done      = 1'b1;
						flags.missing   = st.stop_for_ack;
						nx.stop_for_ack = 1'b0;
					end
				end
				PH_W1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl     = 1'b1;
						nx.delay_count = cfg.ack_setup;
						nx.phase       = PH_W2;
					end
				end
				PH_W2: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.timeout_count = 8'd0;
						nx.phase         = PH_W3;
					end
				end
				PH_W3: begin
					if (!cmd.sda_in) begin
						nx.pin_scl = 1'b0;
						nx.phase   = PH_IDLE;
						flags.done = 1'b1;
					end else if (st.timeout_count >= cfg.ack_timeout) begin
						// No acknowledge: put a stop on the bus and flag it at its end.
						nx.stop_for_ack = 1'b1;
						nx.pin_drive    = 1'b1;
						nx.pin_scl      = 1'b0;
						nx.pin_sda      = 1'b0;
						nx.delay_count  = cfg.start_stop_hold;
						nx.phase        = PH_P1;
					end else begin
						nx.timeout_count = st.timeout_count + 8'd1;
					end
				end
				PH_T1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl     = 1'b1;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_T2;
					end
				end
				PH_T2: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl     = 1'b0;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_T3;
					end
				end
				PH_T3: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.bit_index = bit_inc;
						if (bit_inc >= BYTE_BITS) begin
							nx.phase   = PH_IDLE;
							flags.done = 1'b1;
						end else begin
							nx.pin_sda     = st.shift_data[7];
							nx.shift_data  = {st.shift_data[6:0], 1'b0};
							nx.delay_count = cfg.bit_half_period;
							nx.phase       = PH_T1;
						end
					end
				end
				PH_R1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl = 1'b1;
						nx.phase   = PH_R2;
					end
				end
				PH_R2: begin
					nx.shift_data = rd_shift;
					nx.bit_index  = bit_inc;
					if (bit_inc >= BYTE_BITS) begin
						nx.rx_last     = rd_shift;
						nx.pin_scl     = 1'b0;
						nx.pin_drive   = 1'b1;
						nx.pin_sda     = ~st.ack_choice;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_A1;
					end else begin
						nx.pin_scl     = 1'b0;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_R1;
					end
				end
				PH_A1: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl     = 1'b1;
						nx.delay_count = cfg.bit_half_period;
						nx.phase       = PH_A2;
					end
				end
				PH_A2: begin
					nx.delay_count = dly_dec;
					if (seg_over) begin
						nx.pin_scl = 1'b0;
						nx.phase   = PH_IDLE;
						flags.done = 1'b1;
					end
				end
				default: begin
					nx.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: input register, sequencer state and result register.
//
// The engine takes one word per clock cycle while the result side drains, and returns
// exactly one result word for each. A word is either a bus command (start, stop, wait for
// acknowledge, write byte, read byte) or a tick that advances the running sequence by one
// time unit and carries the sampled SDA level. Every result word reports the SCL level,
// the SDA level and whether SDA is driven, busy, done, the byte of the last completed read,
// and the missing-acknowledge and rejected flags. A command that arrives while a sequence
// is running is ignored and flagged as rejected. Throughput is one word per cycle unless
// the result register stalls. An accepted word sits in the input register while the
// sequencer update settles, and the result register captures the outcome when the word
// is applied; a full result register that is not taken holds the word back. A new word is
// taken into an empty input register while a finished result still waits to be taken.
// Configuration registers (hold, half period, acknowledge setup, acknowledge timeout) are
// written through the plain write port and should only be changed while no word is in
// flight.
module i2c_master_bit_engine (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import i2cm_pkg::*;

	cfg_t   cfg;
	state_t state_q;
	state_t state_nx;
	flags_t flags;

	// Input register stage.
	logic   valid_s1;
	cmd_t   cmd_s1;

	// Result register.
	logic   res_valid_q;
	res_t   res_q;

	logic   advance;

	i2cm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	i2cm_step u_step (
		.st    (state_q),
		.cfg   (cfg),
		.cmd   (cmd_s1),
		.nx    (state_nx),
		.flags (flags)
	);

	// The word in the input register is applied when the result register is free or drains.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	// Sequencer state, including pin levels and the last read byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.delay_count   <= 8'd0;
			state_q.bit_index     <= 4'd0;
			state_q.shift_data    <= 8'd0;
			state_q.timeout_count <= 8'd0;
			state_q.ack_choice    <= 1'b0;
			state_q.pin_scl       <= 1'b1;
			state_q.pin_sda       <= 1'b1;
			state_q.pin_drive     <= 1'b1;
			state_q.stop_for_ack  <= 1'b0;
			state_q.rx_last       <= 8'd0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.scl         <= state_nx.pin_scl;
			res_q.sda_level   <= state_nx.pin_sda;
			res_q.sda_drive   <= state_nx.pin_drive;
			res_q.busy_res    <= (state_nx.phase != PH_IDLE);
			res_q.done_res    <= flags.done;
			res_q.rx_byte     <= state_nx.rx_last;
			res_q.ack_missing <= flags.missing;
			res_q.rejected    <= flags.rejected;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// A rejected word must have met a running sequence.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && flags.rejected) |-> (state_q.phase != PH_IDLE))
		else $error("word rejected while the sequencer was idle");

	// A finished sequence leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && flags.done) |=> (state_q.phase == PH_IDLE))
		else $error("sequence done but sequencer not idle");

	// A missing acknowledge is reported only as the end of its stop.
	a_missing_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.ack_missing) |-> (res_q.done_res && !res_q.busy_res))
		else $error("missing acknowledge reported outside a finished stop");

	// A word in the input register is not held back while the result register is empty.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !res_valid_q) |=> res_valid_q)
		else $error("pending word not applied");

endmodule

[dv/i2c_master_bit_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the I2C master bit engine: bus sequences, ticks, noise and stalls.
module i2c_master_bit_engine_test;
	import i2cm_pkg::*;

	// Kinds 6 and 7 are not commands; the engine must pass them through with no effect.
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	// The limit leaves a wide margin over a run in which every word meets the longest gap and
	// the longest stall, and over an unlucky run with many acknowledge timeouts.
	localparam int CYCLE_LIMIT = 6_000_000;
	// Idle clock cycles that drain() waits after the last result word has come back.
	localparam int SETTLE_CYCLES = 6;

	// Shadow of the engine state as seen at the bus pins and in the sequencer.
	typedef struct packed {
		logic [3:0] phase;
		logic [7:0] hold_left;
		logic [3:0] bits_done;
		logic [7:0] shreg;
		logic [7:0] high_samples;
		logic       send_ack;
		logic       scl;
		logic       sda;
		logic       drive;
		logic       stop_after_nack;
		logic [7:0] last_rx;
	} bus_model_t;

	localparam cfg_t CFG_AT_RESET = '{start_stop_hold: 8'd5, bit_half_period: 8'd2,
		ack_setup: 8'd1, ack_timeout: 8'd250};
	localparam bus_model_t BUS_AT_RESET = '{phase: PH_IDLE, hold_left: 8'd0, bits_done: 4'd0,
		shreg: 8'd0, high_samples: 8'd0, send_ack: 1'b0, scl: 1'b1, sda: 1'b1, drive: 1'b1,
		stop_after_nack: 1'b0, last_rx: 8'd0};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	i2cm_cmd_if cmd_ch();
	i2cm_res_if res_ch();

	i2c_master_bit_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Words waiting to be driven, and result words predicted for words already taken.
	cmd_t pending_words[$];
	res_t expected_results[$];

	// The checking side follows the words the engine really took; the generating side runs
	// its own copy ahead so that it knows how many ticks each sequence needs.
	bus_model_t ref_bus;
	bus_model_t gen_bus;
	cfg_t       ref_cfg;
	cfg_t       gen_cfg;
	res_t       gen_last;
	res_t       want_res;

	int fed_words = 0;
	int results_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int settings_used = 0;
	int done_seen = 0;
	int reject_seen = 0;
	int missing_seen = 0;

	// Number of high SDA samples the simulated slave gives before it pulls SDA low.
	int ack_delay = 0;
	// A value of zero or more pins the next acknowledge delay; negative means random.
	int forced_ack_delay = -1;
	// When set, words that the engine must refuse or ignore are mixed into running sequences.
	bit noise_on = 1'b0;

	int tx_gap_left = 0;
	int tx_calm = 0;
	int rx_stall_left = 0;
	int rx_calm = 0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ---------------------------------------------------------------------------------------
	// Bus predictor
	// ---------------------------------------------------------------------------------------

	// A segment of zero or one tick ends on the next tick; longer ones count down first.
	function automatic logic hold_done(inout logic [7:0] left);
		if (left > 8'd1) begin
			left = left - 8'd1;
			return 1'b0;
		end
		left = 8'd0;
		return 1'b1;
	endfunction

	// Stop condition: both lines low, then SCL high, then SDA high.
	function automatic void begin_stop(inout bus_model_t s, input cfg_t c);
		s.drive = 1'b1;
		s.scl = 1'b0;
		s.sda = 1'b0;
		s.hold_left = c.start_stop_hold;
		s.phase = PH_P1;
	endfunction

	// Put the next transmit bit on SDA, most significant bit first.
	function automatic void load_tx_bit(inout bus_model_t s, input cfg_t c);
		s.sda = s.shreg[7];
		s.shreg = {s.shreg[6:0], 1'b0};
		s.hold_left = c.bit_half_period;
		s.phase = PH_T1;
	endfunction

	function automatic void open_rx_bit(inout bus_model_t s, input cfg_t c);
		s.scl = 1'b0;
		s.hold_left = c.bit_half_period;
		s.phase = PH_R1;
	endfunction

	// Applies one word to the state and returns the result word the engine must give for it.
	function automatic res_t bus_step(inout bus_model_t s, input cfg_t c, input cmd_t w);
		res_t r;
		logic fin;
		logic miss;
		logic refused;
		fin = 1'b0;
		miss = 1'b0;
		refused = 1'b0;
		if (w.kind <= KIND_READ) begin
			if (s.phase != PH_IDLE) begin
				// A command during a sequence leaves the state alone.
				refused = 1'b1;
			end else begin
				case (w.kind)
					KIND_START: begin
						s.drive = 1'b1;
						s.sda = 1'b1;
						s.scl = 1'b1;
						s.hold_left = c.start_stop_hold;
						s.phase = PH_S1;
					end
					KIND_STOP: begin
						s.stop_after_nack = 1'b0;
						begin_stop(s, c);
					end
					KIND_WACK: begin
						s.drive = 1'b0;
						s.sda = 1'b1;
						s.hold_left = c.ack_setup;
						s.phase = PH_W1;
					end
					KIND_WRITE: begin
						s.drive = 1'b1;
						s.scl = 1'b0;
						s.shreg = w.tx_byte;
						s.bits_done = 4'd0;
						load_tx_bit(s, c);
					end
					default: begin
						s.drive = 1'b0;
						s.shreg = 8'd0;
						s.bits_done = 4'd0;
						s.send_ack = w.ack_after_read;
						open_rx_bit(s, c);
					end
				endcase
			end
		end else if (w.kind == KIND_TICK) begin
			case (s.phase)
				PH_S1: if (hold_done(s.hold_left)) begin
					s.sda = 1'b0;
					s.hold_left = c.start_stop_hold;
					s.phase = PH_S2;
				end
				PH_S2: if (hold_done(s.hold_left)) begin
					s.scl = 1'b0;
					s.phase = PH_IDLE;
					fin = 1'b1;
				end
				PH_P1: if (hold_done(s.hold_left)) begin
					s.scl = 1'b1;
					s.hold_left = c.start_stop_hold;
					s.phase = PH_P2;
				end
				PH_P2: if (hold_done(s.hold_left)) begin
					// A stop forced by an acknowledge timeout reports the missing ack here.
					s.sda = 1'b1;
					s.phase = PH_IDLE;
					fin = 1'b1;
					miss = s.stop_after_nack;
					s.stop_after_nack = 1'b0;
				end
				PH_W1: if (hold_done(s.hold_left)) begin
					s.scl = 1'b1;
					s.hold_left = c.ack_setup;
					s.phase = PH_W2;
				end
				PH_W2: if (hold_done(s.hold_left)) begin
					s.high_samples = 8'd0;
					s.phase = PH_W3;
				end
				PH_W3: begin
					// Low SDA is the acknowledge; high samples count toward the timeout.
					if (!w.sda_in) begin
						s.scl = 1'b0;
						s.phase = PH_IDLE;
						fin = 1'b1;
					end else if (s.high_samples >= c.ack_timeout) begin
						s.stop_after_nack = 1'b1;
						begin_stop(s, c);
					end else begin
						s.high_samples = s.high_samples + 8'd1;
					end
				end
				PH_T1: if (hold_done(s.hold_left)) begin
					s.scl = 1'b1;
					s.hold_left = c.bit_half_period;
					s.phase = PH_T2;
				end
				PH_T2: if (hold_done(s.hold_left)) begin
					s.scl = 1'b0;
					s.hold_left = c.bit_half_period;
					s.phase = PH_T3;
				end
				PH_T3: if (hold_done(s.hold_left)) begin
					s.bits_done = s.bits_done + 4'd1;
					if (s.bits_done >= BYTE_BITS) begin
						s.phase = PH_IDLE;
						fin = 1'b1;
					end else begin
						load_tx_bit(s, c);
					end
				end
				PH_R1: if (hold_done(s.hold_left)) begin
					s.scl = 1'b1;
					s.phase = PH_R2;
				end
				PH_R2: begin
					// The tick after SCL rises samples the data bit.
					s.shreg = {s.shreg[6:0], w.sda_in};
					s.bits_done = s.bits_done + 4'd1;
					if (s.bits_done >= BYTE_BITS) begin
						s.last_rx = s.shreg;
						s.scl = 1'b0;
						s.drive = 1'b1;
						s.sda = ~s.send_ack;
						s.hold_left = c.bit_half_period;
						s.phase = PH_A1;
					end else begin
						open_rx_bit(s, c);
					end
				end
				PH_A1: if (hold_done(s.hold_left)) begin
					s.scl = 1'b1;
					s.hold_left = c.bit_half_period;
					s.phase = PH_A2;
				end
				PH_A2: if (hold_done(s.hold_left)) begin
					s.scl = 1'b0;
					s.phase = PH_IDLE;
					fin = 1'b1;
				end
				default: s.phase = PH_IDLE;
			endcase
		end
		r.scl = s.scl;
		r.sda_level = s.sda;
		r.sda_drive = s.drive;
		r.busy_res = (s.phase != PH_IDLE);
		r.done_res = fin;
		r.rx_byte = s.last_rx;
		r.ack_missing = miss;
		r.rejected = refused;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Word generation
	// ---------------------------------------------------------------------------------------

	// Mostly no pause; short pauses often, long ones rarely, and now and then a calm stretch
	// in which the side does not pause at all.
	function automatic int pick_pause(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = int'($urandom_range(0, 199));
		if (roll < 2) begin
			calm = int'($urandom_range(40, 200));
			return 0;
		end
		if (roll < 110) return 0;
		if (roll < 180) return int'($urandom_range(1, 3));
		if (roll < 194) return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	// SDA seen on a tick: the slave answer while the engine waits for an acknowledge,
	// random data otherwise.
	function automatic logic tick_sda();
		if (gen_bus.phase != PH_W3) return 1'($urandom_range(0, 1));
		if (ack_delay == 0) return 1'b0;
		ack_delay--;
		return 1'b1;
	endfunction

	task automatic feed_word(input logic [2:0] k, input logic [7:0] b, input logic a,
			input logic d);
		cmd_t w;
		w = '{kind: k, tx_byte: b, ack_after_read: a, sda_in: d};
		gen_last = bus_step(gen_bus, gen_cfg, w);
		pending_words.push_back(w);
		fed_words++;
	endtask

	// Ticks until the running sequence ends; with noise on, refused commands and spare kinds are mixed in.
	task automatic settle();
		logic [2:0] k;
		logic d;
		int roll;
		while (gen_bus.phase != PH_IDLE) begin
			roll = int'($urandom_range(0, 59));
			d = 1'($urandom_range(0, 1));
			if (noise_on && roll < 4) begin
				k = 3'($urandom_range(KIND_START, KIND_READ));
			end else if (noise_on && roll == 4) begin
				k = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_B));
			end else begin
				k = KIND_TICK;
				d = tick_sda();
			end
			feed_word(k, 8'($urandom), 1'($urandom_range(0, 1)), d);
		end
	endtask

	task automatic run_command(input logic [2:0] k, input logic [7:0] b, input logic a);
		if (k == KIND_WACK) begin
			if (forced_ack_delay >= 0) ack_delay = forced_ack_delay;
			else if ($urandom_range(0, 7) == 0) ack_delay = 1 << 20;
			else ack_delay = int'($urandom_range(0, 5));
		end
		feed_word(k, b, a, 1'($urandom_range(0, 1)));
		settle();
	endtask

	// A bus transfer: start, address write and acknowledge, up to three data bytes, stop.
	// A missing acknowledge ends it early since the engine has sent the stop itself,
	// and once in a while the stop is left out.
	task automatic run_transfer();
		int ops;
		ops = int'($urandom_range(0, 3));
		run_command(KIND_START, 8'($urandom), 1'($urandom_range(0, 1)));
		run_command(KIND_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
		run_command(KIND_WACK, 8'($urandom), 1'($urandom_range(0, 1)));
		if (gen_last.ack_missing) return;
		repeat (ops) begin
			if ($urandom_range(0, 1) == 1) begin
				run_command(KIND_READ, 8'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				run_command(KIND_WRITE, 8'($urandom), 1'($urandom_range(0, 1)));
				run_command(KIND_WACK, 8'($urandom), 1'($urandom_range(0, 1)));
				if (gen_last.ack_missing) return;
			end
		end
		if ($urandom_range(0, 7) != 0) run_command(KIND_STOP, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Between transfers: ticks on an idle bus, spare kinds and lone commands.
	task automatic idle_noise();
		case ($urandom_range(0, 3))
			0: feed_word(KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			1: feed_word(3'($urandom_range(KIND_SPARE_A, KIND_SPARE_B)), 8'($urandom),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			default: run_command(3'($urandom_range(KIND_START, KIND_READ)), 8'($urandom),
				1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic random_phase(input int budget);
		int first;
		first = fed_words;
		noise_on = 1'b1;
		forced_ack_delay = -1;
		while (fed_words - first < budget) begin
			if ($urandom_range(0, 4) == 0) idle_noise();
			else run_transfer();
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Configuration and draining
	// ---------------------------------------------------------------------------------------

	// Waits until every word is driven and every result word has come back, then lets the
	// engine settle. Returns just after a falling edge.
	task automatic drain();
		do @(negedge clk);
		while (pending_words.size() != 0 || cmd_ch.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HOLD: begin
				ref_cfg.start_stop_hold = val;
				gen_cfg.start_stop_hold = val;
			end
			REG_HALF: begin
				ref_cfg.bit_half_period = val;
				gen_cfg.bit_half_period = val;
			end
			REG_SETUP: begin
				ref_cfg.ack_setup = val;
				gen_cfg.ack_setup = val;
			end
			default: begin
				ref_cfg.ack_timeout = val;
				gen_cfg.ack_timeout = val;
			end
		endcase
	endtask

	task automatic set_config(input logic [7:0] hold, input logic [7:0] half,
			input logic [7:0] setup, input logic [7:0] limit);
		drain();
		write_reg(REG_HOLD, hold);
		write_reg(REG_HALF, half);
		write_reg(REG_SETUP, setup);
		write_reg(REG_TIMEOUT, limit);
		settings_used++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// Word driver, result sink, predictor and checker
	// ---------------------------------------------------------------------------------------

	// A new word goes out once the current one is taken, after the pause picked for it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.data <= '0;
			tx_gap_left <= 0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (tx_gap_left != 0) begin
				cmd_ch.valid <= 1'b0;
				tx_gap_left <= tx_gap_left - 1;
			end else if (pending_words.size() != 0) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.data <= pending_words.pop_front();
				tx_gap_left <= pick_pause(tx_calm);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// After each result word taken, the sink may hold ready low for a while.
	always @(posedge clk or negedge arst_n) begin : result_sink
		int nap;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_stall_left <= 0;
		end else if (rx_stall_left != 0) begin
			res_ch.ready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else if (res_ch.valid && res_ch.ready) begin
			nap = pick_pause(rx_calm);
			res_ch.ready <= (nap == 0);
			rx_stall_left <= (nap == 0) ? 0 : nap - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			expected_results.push_back(bus_step(ref_bus, ref_cfg, cmd_ch.data));
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word arrived with no word outstanding");
				mismatches++;
			end else begin
				want_res = expected_results.pop_front();
				check_field("scl", int'(want_res.scl), int'(res_ch.data.scl));
				check_field("sda_level", int'(want_res.sda_level), int'(res_ch.data.sda_level));
				check_field("sda_drive", int'(want_res.sda_drive), int'(res_ch.data.sda_drive));
				check_field("busy_res", int'(want_res.busy_res), int'(res_ch.data.busy_res));
				check_field("done_res", int'(want_res.done_res), int'(res_ch.data.done_res));
				check_field("rx_byte", int'(want_res.rx_byte), int'(res_ch.data.rx_byte));
				check_field("ack_missing", int'(want_res.ack_missing),
					int'(res_ch.data.ack_missing));
				check_field("rejected", int'(want_res.rejected), int'(res_ch.data.rejected));
				done_seen += int'(want_res.done_res);
				missing_seen += int'(want_res.ack_missing);
				reject_seen += int'(want_res.rejected);
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Run stopped at the cycle limit");
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------------------------

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HOLD;
		cfg_data = 8'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		ref_bus = BUS_AT_RESET;
		gen_bus = BUS_AT_RESET;
		ref_cfg = CFG_AT_RESET;
		gen_cfg = CFG_AT_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settings_used = 1;

		// Directed part at the reset register values, no noise.
		noise_on = 1'b0;
		feed_word(KIND_TICK, 8'h00, 1'b0, 1'b1);             // tick on an idle bus
		feed_word(KIND_SPARE_A, 8'hFF, 1'b1, 1'b1);
		feed_word(KIND_SPARE_B, 8'h00, 1'b0, 1'b0);
		feed_word(KIND_START, 8'h00, 1'b0, 1'b1);
		feed_word(KIND_STOP, 8'hFF, 1'b1, 1'b0);              // refused: start still running
		settle();
		run_command(KIND_WRITE, 8'hFF, 1'b0);
		forced_ack_delay = 0;
		run_command(KIND_WACK, 8'h00, 1'b1);
		run_command(KIND_WRITE, 8'h00, 1'b1);
		forced_ack_delay = 2;
		run_command(KIND_WACK, 8'hFF, 1'b0);
		run_command(KIND_READ, 8'h00, 1'b1);
		run_command(KIND_READ, 8'hFF, 1'b0);
		run_command(KIND_STOP, 8'h00, 1'b0);

		// Zero delays make every segment one tick; a zero timeout gives up on the first
		// high sample and stops the bus.
		set_config(8'd0, 8'd0, 8'd0, 8'd0);
		noise_on = 1'b0;
		run_command(KIND_START, 8'h00, 1'b0);
		run_command(KIND_WRITE, 8'hA5, 1'b0);
		forced_ack_delay = 1 << 20;
		run_command(KIND_WACK, 8'h5A, 1'b1);
		forced_ack_delay = 0;
		run_command(KIND_READ, 8'h3C, 1'b1);
		run_command(KIND_WACK, 8'hC3, 1'b0);
		run_command(KIND_STOP, 8'h00, 1'b1);

		// Random transfers, first at the zero setting and then at several others.
		random_phase(120);
		set_config(8'd1, 8'd1, 8'd1, 8'd1);
		random_phase(120);
		set_config(CFG_AT_RESET.start_stop_hold, CFG_AT_RESET.bit_half_period,
			CFG_AT_RESET.ack_setup, CFG_AT_RESET.ack_timeout);
		random_phase(120);
		set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
			8'($urandom_range(0, 3)), 8'($urandom_range(1, 8)));
		random_phase(120);
		set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
			8'($urandom_range(0, 3)), 8'($urandom_range(1, 8)));
		random_phase(120);

		// Start hold and timeout at their top values. The data bits run at a zero half
		// period and the stop is left out, so the section stays short.
		set_config(8'hFF, 8'd0, 8'd0, 8'hFF);
		noise_on = 1'b0;
		forced_ack_delay = 3;
		run_command(KIND_START, 8'h00, 1'b0);
		run_command(KIND_WRITE, 8'h5A, 1'b0);
		run_command(KIND_WACK, 8'hA5, 1'b1);
		run_command(KIND_READ, 8'h0F, 1'b0);

		set_config(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
			8'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
		random_phase(120);

		drain();
		$display("Checked %0d result words for %0d words sent across %0d register settings.",
			results_checked, fed_words, settings_used);
		$display("Sequences ended: %0d, commands refused while busy: %0d, ack timeouts: %0d.",
			done_seen, reject_seen, missing_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
